FILE: hdl/linear_ccd_exposure_control_unit_defines.svh
// Assertion macros for the linear sensor exposure control unit.
// Used by the port checker; no dependencies.
`ifndef LINEAR_CCD_EXPOSURE_CONTROL_UNIT_DEFINES_SVH
`define LINEAR_CCD_EXPOSURE_CONTROL_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CCDAE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CCDAE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/ccdae_pkg.sv
// Shared types and constants for the exposure control unit.
// No dependencies.
`timescale 1ns / 1ps

package ccdae_pkg;

   localparam int LEVEL_W     = 12;
   localparam int WSTART_W    = 7;
   localparam int WEND_W      = 8;
   localparam int PIX_W       = 8;
   localparam int IDX_W       = 7;
   localparam int TICKS_W     = 5;
   localparam int SUM_W       = 15;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;
   localparam int QUEUE_DEPTH = 2;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_LEVEL = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOWER_MARGIN = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UPPER_MARGIN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_START = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_END   = 3'd4;

   localparam logic [LEVEL_W-1:0]  TARGET_LEVEL_RST = 12'd2500;
   localparam logic [LEVEL_W-1:0]  LOWER_MARGIN_RST = 12'd500;
   localparam logic [LEVEL_W-1:0]  UPPER_MARGIN_RST = 12'd200;
   localparam logic [WSTART_W-1:0] WINDOW_START_RST = 7'd0;
   localparam logic [WEND_W-1:0]   WINDOW_END_RST   = 8'd128;

   localparam logic [SUM_W-1:0] SUM_MAX = 15'h7fff;

   typedef struct packed {
      logic [LEVEL_W-1:0]  target_level;
      logic [LEVEL_W-1:0]  lower_margin;
      logic [LEVEL_W-1:0]  upper_margin;
      logic [WSTART_W-1:0] window_start;
      logic [WEND_W-1:0]   window_end;
   } cfg_type;

   // classified request as it travels from front to back
   typedef struct packed {
      logic             is_tick;
      logic             in_window;
      logic             is_last;
      logic [PIX_W-1:0] pixel_value;
   } item_type;

   typedef struct packed {
      logic               start_exposure;
      logic               start_readout;
      logic               frame_done;
      logic [PIX_W-1:0]   mean_level;
      logic [TICKS_W-1:0] exposure_ticks;
      logic [TICKS_W-1:0] phase;
   } result_type;

endpackage

FILE: hdl/ccdae_front.sv
// Front end: accepts requests, classifies tick / pixel / last pixel and window hit.
// Depends on ccdae_pkg.
`timescale 1ns / 1ps

module ccdae_front #(
   parameter int PIXELS = 128
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_mode,
   input  logic [ccdae_pkg::PIX_W-1:0]          req_pixel_value,
   input  logic [ccdae_pkg::IDX_W-1:0]          req_pixel_index,
   input  ccdae_pkg::cfg_type                   cfg,
   output logic                                 push,
   output ccdae_pkg::item_type                  push_item,
   input  logic                                 queue_full
);
   import ccdae_pkg::*;

   localparam logic [8:0] LAST_INDEX = 9'(PIXELS - 1);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;

   assign push      = valid_ff && !queue_full;
   assign push_item = item_ff;
   assign req_stall = valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      item_in = item_ff;
      if (accept) begin
         item_in.is_tick     = !req_mode;
         item_in.in_window   = ({1'b0, req_pixel_index} >= {1'b0, cfg.window_start}) &&
                               ({1'b0, req_pixel_index} <  cfg.window_end);
         item_in.is_last     = req_mode && ({2'b00, req_pixel_index} == LAST_INDEX);
         item_in.pixel_value = req_pixel_value;
      end
      valid_in = accept || (valid_ff && queue_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

FILE: hdl/ccdae_queue.sv
// Two-entry request queue between front and back.
// Depends on ccdae_pkg.
`timescale 1ns / 1ps

module ccdae_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ccdae_pkg::item_type push_item,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output ccdae_pkg::item_type head_item
);
   import ccdae_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

   item_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == DEPTH_CNT);
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: hdl/ccdae_div.sv
// Restoring divider, one quotient bit per cycle: window sum / window length.
// Depends on ccdae_pkg.
`timescale 1ns / 1ps

module ccdae_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [ccdae_pkg::SUM_W-1:0]         dividend,
   input  logic [ccdae_pkg::WEND_W-1:0]        divisor,
   output logic                                done,
   output logic [ccdae_pkg::SUM_W-1:0]         quotient
);
   import ccdae_pkg::*;

   localparam int CNT_W = $clog2(SUM_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(SUM_W - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [WEND_W-1:0]   rem_ff, rem_in;
   logic [WEND_W-1:0]   div_ff, div_in;
   logic [SUM_W-1:0]    quo_ff, quo_in;
   logic [WEND_W:0]     trial;
   logic [WEND_W:0]     diff;
   logic                fits;

   assign trial    = {rem_ff, quo_ff[SUM_W-1]};
   assign diff     = trial - {1'b0, div_ff};
   assign fits     = (trial >= {1'b0, div_ff});
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         div_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the low bits hold it
         rem_in = fits ? diff[WEND_W-1:0] : trial[WEND_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

endmodule

FILE: hdl/ccdae_back.sv
// Back end: frame phase, window sum, exposure time update and result register.
// Depends on ccdae_pkg and ccdae_div.
`timescale 1ns / 1ps

module ccdae_back #(
   parameter int PERIOD = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ccdae_pkg::cfg_type     cfg,
   input  logic                   head_valid,
   input  ccdae_pkg::item_type    head_item,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ccdae_pkg::result_type  rsp
);
   import ccdae_pkg::*;

   localparam logic [TICKS_W-1:0] PERIOD_T = TICKS_W'(PERIOD);
   localparam logic [TICKS_W:0]   PERIOD_X = (TICKS_W + 1)'(PERIOD);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_ADJUST = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [TICKS_W-1:0] phase_ff, phase_in;
   logic [TICKS_W-1:0] itime_ff, itime_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [PIX_W-1:0]   mean_ff, mean_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;

   logic               out_free;
   logic [TICKS_W-1:0] phase_base, phase_inc, phase_new;
   logic signed [6:0]  point;
   logic               expo, readout;
   logic [SUM_W:0]     sum_add;
   logic [SUM_W-1:0]   sum_sat, sum_new;
   logic [WEND_W:0]    len;
   logic               len_pos;
   logic               div_start, div_done;
   logic [SUM_W-1:0]   div_quo;
   logic signed [13:0] err, lower_neg, upper_pos;
   logic               dec, inc;
   logic [TICKS_W:0]   t_step, t_adj;
   logic [TICKS_W-1:0] itime_new;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = (state_ff == ST_IDLE) && head_valid && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // tick path; a phase at or above the period wraps as if at the period
   assign phase_base = (phase_ff >= PERIOD_T) ? '0 : phase_ff;
   assign phase_inc  = phase_base + 1'b1;
   assign point      = $signed({2'b00, PERIOD_T}) - $signed({2'b00, itime_ff});
   assign expo       = (point >= 7'sd2) && (point == $signed({2'b00, phase_inc}));
   assign readout    = (phase_inc == PERIOD_T);
   assign phase_new  = readout ? '0 : phase_inc;

   // pixel path, saturating sum
   assign sum_add = {1'b0, sum_ff} + {{(SUM_W + 1 - PIX_W){1'b0}}, head_item.pixel_value};
   assign sum_sat = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
   assign sum_new = head_item.in_window ? sum_sat : sum_ff;

   assign len       = {1'b0, cfg.window_end} - {2'b00, cfg.window_start};
   assign len_pos   = !len[WEND_W] && (len != '0);
   assign div_start = pop && !head_item.is_tick && head_item.is_last && len_pos;

   ccdae_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_new),
      .divisor  (len[WEND_W-1:0]),
      .done     (div_done),
      .quotient (div_quo)
   );

   // time update from the registered mean
   assign err       = $signed({2'b00, cfg.target_level}) - $signed({6'b0, mean_ff});
   assign lower_neg = -$signed({2'b00, cfg.lower_margin});
   assign upper_pos = $signed({2'b00, cfg.upper_margin});
   assign dec       = (err < lower_neg);
   assign inc       = (err > upper_pos);

   always_comb begin
      t_step = {1'b0, itime_ff};
      if (dec) begin
         t_step = (itime_ff == '0) ? PERIOD_X : {1'b0, itime_ff} - 1'b1;
      end
      t_adj = inc ? t_step + 1'b1 : t_step;
      if (t_adj == '0) begin
         itime_new = TICKS_W'(1);
      end else if (t_adj > PERIOD_X) begin
         itime_new = PERIOD_T;
      end else begin
         itime_new = t_adj[TICKS_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      itime_in     = itime_ff;
      sum_in       = sum_ff;
      mean_in      = mean_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               if (head_item.is_tick) begin
                  phase_in     = phase_new;
                  rsp_in       = '{expo, readout, 1'b0, mean_ff, itime_ff, phase_new};
                  rsp_valid_in = 1'b1;
               end else if (!head_item.is_last) begin
                  sum_in       = sum_new;
                  rsp_in       = '{1'b0, 1'b0, 1'b0, mean_ff, itime_ff, phase_ff};
                  rsp_valid_in = 1'b1;
               end else begin
                  sum_in = '0;
                  if (len_pos) begin
                     state_in = ST_DIVIDE;
                  end else begin
                     mean_in  = '0;
                     state_in = ST_ADJUST;
                  end
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               mean_in  = (div_quo > SUM_W'(255)) ? 8'hff : div_quo[PIX_W-1:0];
               state_in = ST_ADJUST;
            end
         end
         ST_ADJUST: begin
            // result slot is empty here: it was free when the request was taken
            itime_in     = itime_new;
            rsp_in       = '{1'b0, 1'b0, 1'b1, mean_ff, itime_new, phase_ff};
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         itime_ff     <= '0;
         sum_ff       <= '0;
         mean_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         itime_ff     <= itime_in;
         sum_ff       <= sum_in;
         mean_ff      <= mean_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

endmodule

FILE: hdl/linear_ccd_exposure_control_unit.sv
// Exposure control unit for a linear image sensor. Tick and pixel requests pass
// through the front register, the queue and the back result register; the back
// end takes one request per cycle while idle with an empty or unstalled result slot.
// The last pixel of a frame runs the 15-step serial divider for the window mean
// when the window is non-empty. Synchronous active-high reset clears control,
// phase, time, sum and mean state, and loads the register defaults.
`timescale 1ns / 1ps

module linear_ccd_exposure_control_unit #(
   parameter int PERIOD = 20,
   parameter int PIXELS = 128
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_mode,
   input  logic [ccdae_pkg::PIX_W-1:0]          req_pixel_value,
   input  logic [ccdae_pkg::IDX_W-1:0]          req_pixel_index,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_start_exposure,
   output logic                                 rsp_start_readout,
   output logic                                 rsp_frame_done,
   output logic [ccdae_pkg::PIX_W-1:0]          rsp_mean_level,
   output logic [ccdae_pkg::TICKS_W-1:0]        rsp_exposure_ticks,
   output logic [ccdae_pkg::TICKS_W-1:0]        rsp_phase,
   input  logic                                 csr_write_enable,
   input  logic [ccdae_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ccdae_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import ccdae_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       push, queue_full, pop, head_valid;
   item_type   push_item, head_item;
   result_type rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_TARGET_LEVEL: cfg_in.target_level = csr_write_data;
            CSR_LOWER_MARGIN: cfg_in.lower_margin = csr_write_data;
            CSR_UPPER_MARGIN: cfg_in.upper_margin = csr_write_data;
            CSR_WINDOW_START: cfg_in.window_start = csr_write_data[WSTART_W-1:0];
            CSR_WINDOW_END:   cfg_in.window_end   = csr_write_data[WEND_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{TARGET_LEVEL_RST, LOWER_MARGIN_RST, UPPER_MARGIN_RST,
                    WINDOW_START_RST, WINDOW_END_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ccdae_front #(
      .PIXELS (PIXELS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_pixel_value (req_pixel_value),
      .req_pixel_index (req_pixel_index),
      .cfg             (cfg_ff),
      .push            (push),
      .push_item       (push_item),
      .queue_full      (queue_full)
   );

   ccdae_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   ccdae_back #(
      .PERIOD (PERIOD)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   assign rsp_start_exposure = rsp.start_exposure;
   assign rsp_start_readout  = rsp.start_readout;
   assign rsp_frame_done     = rsp.frame_done;
   assign rsp_mean_level     = rsp.mean_level;
   assign rsp_exposure_ticks = rsp.exposure_ticks;
   assign rsp_phase          = rsp.phase;

endmodule

FILE: hdl/ccdae_checker.sv
// Port-level checker for the exposure control unit, bound to the top level.
// Depends on ccdae_pkg and linear_ccd_exposure_control_unit_defines.svh.
`timescale 1ns / 1ps

module ccdae_checker #(
   parameter int PERIOD = 20
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 req_mode,
   input logic [ccdae_pkg::PIX_W-1:0]          req_pixel_value,
   input logic [ccdae_pkg::IDX_W-1:0]          req_pixel_index,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic                                 rsp_start_exposure,
   input logic                                 rsp_start_readout,
   input logic                                 rsp_frame_done,
   input logic [ccdae_pkg::PIX_W-1:0]          rsp_mean_level,
   input logic [ccdae_pkg::TICKS_W-1:0]        rsp_exposure_ticks,
   input logic [ccdae_pkg::TICKS_W-1:0]        rsp_phase,
   input logic                                 csr_write_enable,
   input logic [ccdae_pkg::CSR_INDEX_W-1:0]    csr_index,
   input logic [ccdae_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import ccdae_pkg::*;

   `include "linear_ccd_exposure_control_unit_defines.svh"

   localparam logic [TICKS_W-1:0] PERIOD_T = TICKS_W'(PERIOD);

   // a frame close is a pixel request, never a tick
   `CCDAE_ASSERT_NOW(a_done_not_tick, clock, reset, rsp_valid && rsp_frame_done, !rsp_start_exposure && !rsp_start_readout, "frame close carries tick flags")

   `CCDAE_ASSERT_NOW(a_done_time_range, clock, reset, rsp_valid && rsp_frame_done, (rsp_exposure_ticks != '0) && (rsp_exposure_ticks <= PERIOD_T), "exposure time out of range after update")

   `CCDAE_ASSERT_NOW(a_readout_wraps, clock, reset, rsp_valid && rsp_start_readout, rsp_phase == '0, "readout without phase wrap")

   `CCDAE_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_phase) && $stable(rsp_exposure_ticks), "stalled response dropped or changed")

endmodule

bind linear_ccd_exposure_control_unit ccdae_checker #(
   .PERIOD (PERIOD)
) u_ccdae_checker (.*);
